// File: design/fifo_greedy_order_allocator_core_macros.svh
// Assertion macros used by the order allocator core
`ifndef FIFO_GREEDY_ORDER_ALLOCATOR_CORE_MACROS_SVH
`define FIFO_GREEDY_ORDER_ALLOCATOR_CORE_MACROS_SVH

// invariant checked on every edge out of reset
`define FOA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition on one edge implies another on the next edge
`define FOA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: design/foa_pkg.sv
// Shared types and constants of the order allocator
`default_nettype none
package foa_pkg;
   localparam int DefaultDepth   = 16;
   localparam int DefaultColumns = 4;
   localparam int AmountWidth    = 32;
   localparam int TagWidth       = 32;
   localparam int MaxColumns     = 4;

   typedef enum logic [1:0] {
      MODE_APPEND   = 2'd0,
      MODE_REMOVE   = 2'd1,
      MODE_READ     = 2'd2,
      MODE_ALLOCATE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ACK      = 2'd0,
      KIND_READ     = 2'd1,
      KIND_RECORD   = 2'd2,
      KIND_LEFTOVER = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_ALLOC,
      ST_LEFTOVER
   } state_type;

   // per-cell control: load own entry from the next cell, or from the write bus
   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctl_type;
endpackage
`default_nettype wire

// File: design/foa_cell.sv
// One queue cell: holds a tag and its quantities, loads from its neighbour or from the write bus
`default_nettype none
module foa_cell
   import foa_pkg::*;
#(
   parameter int COLUMNS = DefaultColumns
) (
   input  wire                                    clock,
   input  wire  cell_ctl_type                     ctl,
   input  wire  [TagWidth-1:0]                    wr_tag,
   input  wire  [COLUMNS-1:0][AmountWidth-1:0]    wr_amt,
   input  wire  [TagWidth-1:0]                    nb_tag,
   input  wire  [COLUMNS-1:0][AmountWidth-1:0]    nb_amt,
   output logic [TagWidth-1:0]                    tag,
   output logic [COLUMNS-1:0][AmountWidth-1:0]    amt
);
   logic [TagWidth-1:0]                 tag_ff, tag_in;
   logic [COLUMNS-1:0][AmountWidth-1:0] amt_ff, amt_in;

   always_comb begin
      tag_in = tag_ff;
      amt_in = amt_ff;
      if (ctl.write) begin
         tag_in = wr_tag;
         amt_in = wr_amt;
      end else if (ctl.shift) begin
         tag_in = nb_tag;
         amt_in = nb_amt;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      amt_ff <= amt_in;
   end

   assign tag = tag_ff;
   assign amt = amt_ff;
endmodule
`default_nettype wire

// File: design/fifo_greedy_order_allocator_core.sv
// Order allocator: request handshake, control sequencer and the cell chain
//
// Channels: req_ carries one command word (append, remove, read, allocate),
// rsp_ returns the result words, csr_ writes the active column count.
// Append, remove and read give one word in the cycle after acceptance; the
// queue is updated in that same cycle, so the next command is taken at once
// if the result register is free.
// Allocate walks the chain twice, one order a cycle: a counting pass that
// rotates the queue to learn the final occupancy, then the allocating pass
// that emits one record per order given a nonzero share and compacts the
// queue (waiting while the receiver stalls), then the leftover word. The
// next command is taken after the leftover word is registered; the rate is
// set by the single head-of-chain min/subtract unit.
// tlast marks the final word of each command.
// Reset empties the queue and sets four active columns; no clearing pass.
// When the receiver stalls, the result register holds and the allocating
// pass waits; req_tready stays low until the command has finished.
`default_nettype none
module fifo_greedy_order_allocator_core
   import foa_pkg::*;
#(
   parameter int DEPTH   = DefaultDepth,
   parameter int COLUMNS = DefaultColumns
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // tag[31:0], amount_a[63:32], amount_b[95:64], amount_c[127:96],
   // amount_d[159:128], position[163:160], zero pad
   input  wire  [167:0] req_tdata,
   // mode[1:0]
   input  wire  [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // result_tag[31:0], result_a[63:32], result_b[95:64], result_c[127:96],
   // result_d[159:128], occupancy[164:160], zero pad
   output logic [167:0] rsp_tdata,
   // kind[1:0], status[3:2]
   output logic [3:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_data
);
`include "fifo_greedy_order_allocator_core_macros.svh"

   localparam int CW = $clog2(DEPTH + 1);

   typedef logic [COLUMNS-1:0][AmountWidth-1:0] amt_row_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] w_ff, w_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [2:0]    cols_ff;
   logic [MaxColumns-1:0][AmountWidth-1:0] avail_ff, avail_in;
   logic [MaxColumns-1:0][AmountWidth-1:0] orig_ff, orig_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [167:0] rsp_data_ff, rsp_data_in;
   logic [3:0]   rsp_user_ff, rsp_user_in;
   logic         rsp_last_ff, rsp_last_in;

   logic [MaxColumns-1:0] act;
   logic out_free;
   logic req_acc;

   mode_type                mode;
   logic [TagWidth-1:0]     in_tag;
   logic [MaxColumns-1:0][AmountWidth-1:0] in_amt;
   logic [3:0]              in_pos;

   cell_ctl_type [DEPTH-1:0] ctl;
   logic [TagWidth-1:0]      wr_tag;
   amt_row_type              wr_amt;
   logic [CW-1:0]            wr_idx;
   logic                     wr_en;
   logic                     shift_all;

   logic [DEPTH-1:0][TagWidth-1:0] cell_tag;
   amt_row_type [DEPTH-1:0]        cell_amt;

   logic [MaxColumns-1:0][AmountWidth-1:0] take, remain, head_need;
   logic got, left;
   logic pos_ok;
   logic [TagWidth-1:0] rd_tag;
   amt_row_type         rd_amt;

   assign mode   = mode_type'(req_tuser);
   assign in_tag = req_tdata[31:0];
   assign in_pos = req_tdata[163:160];
   always_comb begin
      for (int j = 0; j < MaxColumns; j++)
         in_amt[j] = req_tdata[32 + 32*j +: 32];
   end

   // active columns: zero acts as one, above COLUMNS acts as COLUMNS
   always_comb begin
      for (int j = 0; j < MaxColumns; j++)
         act[j] = (j == 0) || ((j < COLUMNS) && (32'(j) < 32'(cols_ff)));
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign pos_ok     = 32'(in_pos) < 32'(count_ff);

   // read port over the chain
   always_comb begin
      rd_tag = '0;
      rd_amt = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (32'(in_pos) == 32'(i)) begin
            rd_tag = cell_tag[i];
            rd_amt = cell_amt[i];
         end
      end
   end

   // head of chain: take the lesser of need and what is still available
   always_comb begin
      got  = 1'b0;
      left = 1'b0;
      for (int j = 0; j < MaxColumns; j++) begin
         head_need[j] = '0;
         take[j]      = '0;
         remain[j]    = '0;
         if (j < COLUMNS) head_need[j] = cell_amt[0][j];
         if (act[j]) begin
            take[j]   = (head_need[j] < avail_ff[j]) ? head_need[j] : avail_ff[j];
            remain[j] = head_need[j] - take[j];
            if (take[j] != '0)   got  = 1'b1;
            if (remain[j] != '0) left = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_acc && mode == MODE_ALLOCATE) state_in = ST_COUNT;
         ST_COUNT:    if (k_ff == '0) state_in = ST_ALLOC;
         ST_ALLOC:    if (k_ff == '0) state_in = ST_LEFTOVER;
         ST_LEFTOVER: if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and chain control
   always_comb begin
      count_in     = count_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      keep_in      = keep_ff;
      avail_in     = avail_ff;
      orig_in      = orig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_idx       = '0;
      wr_tag       = cell_tag[0];
      wr_amt       = cell_amt[0];
      shift_all    = 1'b0;
      for (int i = 0; i < DEPTH; i++) ctl[i] = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = {STATUS_OK, KIND_ACK};
               case (mode)
                  MODE_APPEND: begin
                     if (count_ff >= CW'(DEPTH)) begin
                        rsp_user_in = {STATUS_FULL, KIND_ACK};
                     end else begin
                        wr_en  = 1'b1;
                        wr_idx = count_ff;
                        wr_tag = in_tag;
                        for (int j = 0; j < COLUMNS; j++)
                           wr_amt[j] = act[j] ? in_amt[j] : '0;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_REMOVE: begin
                     if (!pos_ok) begin
                        rsp_user_in = {STATUS_RANGE, KIND_ACK};
                     end else begin
                        for (int i = 0; i < DEPTH; i++)
                           ctl[i].shift = (32'(i) >= 32'(in_pos));
                        count_in = count_ff - 1'b1;
                     end
                  end
                  MODE_READ: begin
                     if (!pos_ok) begin
                        rsp_user_in = {STATUS_RANGE, KIND_READ};
                     end else begin
                        rsp_user_in        = {STATUS_OK, KIND_READ};
                        rsp_data_in[31:0]  = rd_tag;
                        for (int j = 0; j < COLUMNS; j++)
                           if (act[j]) rsp_data_in[32 + 32*j +: 32] = rd_amt[j];
                     end
                  end
                  default: begin
                     // allocate: no word yet
                     rsp_valid_in = rsp_valid_ff && !rsp_tready;
                     rsp_data_in  = rsp_data_ff;
                     rsp_user_in  = rsp_user_ff;
                     rsp_last_in  = rsp_last_ff;
                     for (int j = 0; j < MaxColumns; j++) begin
                        avail_in[j] = act[j] ? in_amt[j] : '0;
                        orig_in[j]  = act[j] ? in_amt[j] : '0;
                     end
                     k_in    = count_ff;
                     keep_in = '0;
                  end
               endcase
               rsp_data_in[164:160] = 5'(count_in);
            end
         end
         ST_COUNT: begin
            // rotate head to tail, counting orders that stay partly open
            if (k_ff != '0) begin
               shift_all = 1'b1;
               wr_en     = 1'b1;
               wr_idx    = count_ff - 1'b1;
               avail_in  = avail_ff;
               for (int j = 0; j < MaxColumns; j++) avail_in[j] = avail_ff[j] - take[j];
               if (left) keep_in = keep_ff + 1'b1;
               k_in = k_ff - 1'b1;
            end else begin
               avail_in = orig_ff;
               k_in     = count_ff;
               w_in     = '0;
            end
         end
         ST_ALLOC: begin
            if (k_ff != '0 && out_free) begin
               shift_all = 1'b1;
               for (int j = 0; j < MaxColumns; j++) avail_in[j] = avail_ff[j] - take[j];
               if (left) begin
                  wr_en  = 1'b1;
                  wr_idx = k_ff - 1'b1 + w_ff;
                  for (int j = 0; j < COLUMNS; j++)
                     if (act[j]) wr_amt[j] = remain[j];
                  w_in = w_ff + 1'b1;
               end
               k_in = k_ff - 1'b1;
               if (got) begin
                  rsp_valid_in         = 1'b1;
                  rsp_last_in          = 1'b0;
                  rsp_user_in          = {STATUS_OK, KIND_RECORD};
                  rsp_data_in          = '0;
                  rsp_data_in[31:0]    = cell_tag[0];
                  for (int j = 0; j < MaxColumns; j++)
                     rsp_data_in[32 + 32*j +: 32] = take[j];
                  rsp_data_in[164:160] = 5'(keep_ff);
               end
            end
         end
         ST_LEFTOVER: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_last_in          = 1'b1;
               rsp_user_in          = {STATUS_OK, KIND_LEFTOVER};
               rsp_data_in          = '0;
               for (int j = 0; j < MaxColumns; j++)
                  rsp_data_in[32 + 32*j +: 32] = avail_ff[j];
               rsp_data_in[164:160] = 5'(w_ff);
               count_in             = w_ff;
            end
         end
         default: ;
      endcase

      if (shift_all)
         for (int i = 0; i < DEPTH; i++) ctl[i].shift = 1'b1;
      if (wr_en)
         for (int i = 0; i < DEPTH; i++) ctl[i].write = (wr_idx == CW'(i));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         w_ff         <= '0;
         keep_ff      <= '0;
         cols_ff      <= 3'd4;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         w_ff         <= w_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) cols_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      avail_ff    <= avail_in;
      orig_ff     <= orig_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [TagWidth-1:0] nb_tag;
      amt_row_type         nb_amt;
      if (i == DEPTH - 1) begin : g_end
         assign nb_tag = '0;
         assign nb_amt = '0;
      end else begin : g_mid
         assign nb_tag = cell_tag[i+1];
         assign nb_amt = cell_amt[i+1];
      end
      foa_cell #(.COLUMNS(COLUMNS)) u_cell (
         .clock  (clock),
         .ctl    (ctl[i]),
         .wr_tag (wr_tag),
         .wr_amt (wr_amt),
         .nb_tag (nb_tag),
         .nb_amt (nb_amt),
         .tag    (cell_tag[i]),
         .amt    (cell_amt[i])
      );
   end

   `FOA_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "occupancy above depth")
   `FOA_ASSERT_ALWAYS(a_busy_no_req, clock, reset, (state_ff == ST_IDLE) || !req_tready, "request taken while busy")
   `FOA_ASSERT_ALWAYS(a_alloc_bound, clock, reset, (state_ff != ST_ALLOC) || (32'(k_ff) + 32'(w_ff) <= 32'(count_ff)), "allocate indices overrun queue")
   `FOA_ASSERT_NEXT(a_leftover_last, clock, reset, (state_ff == ST_LEFTOVER) && out_free, rsp_tvalid && rsp_tlast && (state_ff == ST_IDLE), "leftover word not final")
endmodule
`default_nettype wire
